>>> sv/bptc_pkg.sv
`default_nettype none

package bptc_pkg;

    // widths shared between the top level and the pressure multiplier
    localparam int RAW_W  = 24;
    localparam int SENS_W = 39;
    localparam int PROD_W = 64;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SENS       = 3'd0,
        CFG_OFFSET     = 3'd1,
        CFG_SENS_TC    = 3'd2,
        CFG_OFFSET_TC  = 3'd3,
        CFG_REF_TEMP   = 3'd4,
        CFG_TEMP_SLOPE = 3'd5,
        CFG_MATH_MODE  = 3'd6
    } cfg_idx_t;

    // calibration reset values
    localparam logic [15:0] SENS_RST       = 16'd40127;
    localparam logic [15:0] OFFSET_RST     = 16'd36924;
    localparam logic [15:0] SENS_TC_RST    = 16'd23317;
    localparam logic [15:0] OFFSET_TC_RST  = 16'd23282;
    localparam logic [15:0] REF_TEMP_RST   = 16'd33464;
    localparam logic [15:0] TEMP_SLOPE_RST = 16'd28312;

    // temperature constants in 0.01 C
    localparam logic signed [18:0] TEMP_REF   = 19'sd2000;
    localparam logic signed [18:0] COLD_DELTA = -19'sd3500;
    localparam logic signed [18:0] COLD_SHIFT = 19'sd3500;
    localparam logic signed [19:0] TEMP_LOW   = -20'sd4000;
    localparam logic signed [19:0] TEMP_HIGH  = 20'sd8500;

    // pressure clamp in Pa
    localparam logic signed [28:0] PRESS_HIGH = 29'sd131071;

endpackage

`default_nettype wire

>>> sv/baro_pressure_temp_compensation.sv
`default_nettype none

// channel     | signals                                      | transfer when
// ------------+----------------------------------------------+------------------------
// sample in   | start, busy, pressure_raw, temperature_raw   | start && !busy
// config      | cfg_valid, cfg_ready, cfg_index, cfg_data    | cfg_valid && cfg_ready
// result out  | done, temperature_centi, pressure_pa,        | done (one cycle)
//             | out_of_range                                 |
//
// ten-stage pipeline: a sample pair enters on any cycle and its result strobes
// out on done after stage 10, one result per cycle at full rate
// busy stays low and cfg_ready stays high; the receiver cannot stall, so
// valid bits just shift along with the data
// rst_n clears the stage valid bits and loads the calibration defaults
// the 24 x 39 bit pressure product is split over two stages in bptc_mul

module baro_pressure_temp_compensation (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [23:0]        pressure_raw,
    input  wire logic [23:0]        temperature_raw,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    done,
    output logic signed [14:0]      temperature_centi,
    output logic [16:0]             pressure_pa,
    output logic                    out_of_range
);
    import bptc_pkg::*;

    // calibration registers
    logic [15:0] sens_coeff_reg;
    logic [15:0] offset_coeff_reg;
    logic [15:0] sens_temp_coeff_reg;
    logic [15:0] offset_temp_coeff_reg;
    logic [15:0] ref_temp_reg;
    logic [15:0] temp_slope_reg;
    logic        math_mode_reg;

    // stage valid bits
    logic [6:1] v_reg;
    logic       v9_reg;
    logic       v10_reg;
    logic       mul_valid;

    // stage 1: dT
    logic [23:0]        d1_s1_reg;
    logic signed [24:0] dt_s1_reg;
    logic signed [24:0] dt_next;

    // stage 2: products against dT
    logic [23:0]        d1_s2_reg;
    logic signed [41:0] prod_t_reg, prod_t_next;
    logic signed [41:0] off_dt_reg, off_dt_next;
    logic signed [41:0] sens_dt_reg, sens_dt_next;
    logic [47:0]        dt_sq_reg;
    logic signed [49:0] dt_sq_next;

    // stage 3: first-order terms
    logic [23:0]        d1_s3_reg;
    logic signed [17:0] delta_s3_reg, delta_next;
    logic signed [18:0] temp_s3_reg, temp_next;
    logic signed [39:0] off_s3_reg, off_next, off_base, off_term;
    logic signed [38:0] sens_s3_reg, sens_next, sens_base, sens_term;
    logic [16:0]        t2_s3_reg;
    logic               cold_s3_reg, cold_next;
    logic               frigid_s3_reg, frigid_next;

    // stage 4: squares for the second-order terms
    logic [23:0]        d1_s4_reg;
    logic signed [18:0] temp_s4_reg;
    logic signed [39:0] off_s4_reg;
    logic signed [38:0] sens_s4_reg;
    logic [16:0]        t2_s4_reg;
    logic               cold_s4_reg;
    logic               frigid_s4_reg;
    logic [34:0]        a_reg;
    logic [35:0]        b_reg;
    logic signed [35:0] a_sq;
    logic signed [18:0] shifted;
    logic signed [37:0] b_sq;

    // stage 5: OFF2 and SENS2
    logic [23:0]        d1_s5_reg;
    logic signed [18:0] temp_s5_reg;
    logic signed [39:0] off_s5_reg;
    logic signed [38:0] sens_s5_reg;
    logic [16:0]        t2_s5_reg;
    logic               cold_s5_reg;
    logic [38:0]        off2_reg, off2_next;
    logic [37:0]        sens2_reg, sens2_next;
    logic [36:0]        a_x5;
    logic [38:0]        b_x7;
    logic [39:0]        b_x11;

    // stage 6: corrections applied
    logic [23:0]        d1_s6_reg;
    logic signed [19:0] temp_s6_reg, temp_c;
    logic signed [39:0] off_s6_reg, off_c;
    logic signed [38:0] sens_s6_reg, sens_c;

    // stages 7 and 8 run inside the multiplier, these ride alongside
    logic signed [19:0] temp_s7_reg, temp_s8_reg;
    logic signed [39:0] off_s7_reg, off_s8_reg;
    logic signed [63:0] prod;

    // stage 9: subtract the offset
    logic signed [19:0] temp_s9_reg;
    logic signed [43:0] x_reg, x_next;

    // stage 10: clamp into the output ranges
    logic signed [28:0] press_wide;
    logic signed [14:0] temp_out_reg, temp_out_next;
    logic [16:0]        press_out_reg, press_out_next;
    logic               oor_reg, oor_next;

    // no stall anywhere in the pipe
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration write, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_coeff_reg        <= SENS_RST;
            offset_coeff_reg      <= OFFSET_RST;
            sens_temp_coeff_reg   <= SENS_TC_RST;
            offset_temp_coeff_reg <= OFFSET_TC_RST;
            ref_temp_reg          <= REF_TEMP_RST;
            temp_slope_reg        <= TEMP_SLOPE_RST;
            math_mode_reg         <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SENS:       sens_coeff_reg        <= cfg_data;
                CFG_OFFSET:     offset_coeff_reg      <= cfg_data;
                CFG_SENS_TC:    sens_temp_coeff_reg   <= cfg_data;
                CFG_OFFSET_TC:  offset_temp_coeff_reg <= cfg_data;
                CFG_REF_TEMP:   ref_temp_reg          <= cfg_data;
                CFG_TEMP_SLOPE: temp_slope_reg        <= cfg_data;
                CFG_MATH_MODE:  math_mode_reg         <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        // stage 1: dT = D2 - C5 * 2^8
        dt_next = $signed({1'b0, temperature_raw}) - $signed({1'b0, ref_temp_reg, 8'b0});

        // stage 2: one multiplier deep, four in parallel
        prod_t_next  = dt_s1_reg * $signed({1'b0, temp_slope_reg});
        off_dt_next  = dt_s1_reg * $signed({1'b0, offset_temp_coeff_reg});
        sens_dt_next = dt_s1_reg * $signed({1'b0, sens_temp_coeff_reg});
        dt_sq_next   = dt_s1_reg * dt_s1_reg;

        // stage 3: floor shifts are arithmetic, mode 1 doubles the scales
        delta_next = $signed(prod_t_reg[40:23]);
        temp_next  = TEMP_REF + 19'(delta_next);
        if (math_mode_reg)
        begin
            off_base  = $signed({7'b0, offset_coeff_reg, 17'b0});
            off_term  = 40'(off_dt_reg >>> 6);
            sens_base = $signed({7'b0, sens_coeff_reg, 16'b0});
            sens_term = 39'(sens_dt_reg >>> 7);
        end
        else
        begin
            off_base  = $signed({8'b0, offset_coeff_reg, 16'b0});
            off_term  = 40'(off_dt_reg >>> 7);
            sens_base = $signed({8'b0, sens_coeff_reg, 15'b0});
            sens_term = 39'(sens_dt_reg >>> 8);
        end
        off_next    = off_base + off_term;
        sens_next   = sens_base + sens_term;
        cold_next   = delta_next < 18'sd0;
        frigid_next = 19'(delta_next) < COLD_DELTA;

        // stage 4: (TEMP - 2000)^2 and (TEMP + 1500)^2
        a_sq    = delta_s3_reg * delta_s3_reg;
        shifted = 19'(delta_s3_reg) + COLD_SHIFT;
        b_sq    = shifted * shifted;

        // stage 5: OFF2 = 5a/2 + 7b, SENS2 = 5a/4 + 11b/2, b only when frigid
        a_x5       = {a_reg, 2'b00} + {2'b00, a_reg};
        b_x7       = {b_reg, 3'b000} - {3'b000, b_reg};
        b_x11      = {1'b0, b_reg, 3'b000} + {3'b000, b_reg, 1'b0} + {4'b0000, b_reg};
        off2_next  = {3'b000, a_x5[36:1]} + (frigid_s4_reg ? b_x7 : 39'd0);
        sens2_next = {3'b000, a_x5[36:2]} + (frigid_s4_reg ? b_x11[38:1] : 38'd0);

        // stage 6: second-order correction below 20.00 C
        if (cold_s5_reg)
        begin
            temp_c = 20'(temp_s5_reg) - $signed({3'b000, t2_s5_reg});
            off_c  = off_s5_reg - $signed({1'b0, off2_reg});
            sens_c = sens_s5_reg - $signed({1'b0, sens2_reg});
        end
        else
        begin
            temp_c = 20'(temp_s5_reg);
            off_c  = off_s5_reg;
            sens_c = sens_s5_reg;
        end

        // stage 9: floor(D1 * SENS / 2^21) - OFF
        x_next = 44'($signed(prod[63:21])) - 44'(off_s8_reg);

        // stage 10: divide by 2^15 and saturate
        press_wide = $signed(x_reg[43:15]);
        oor_next   = 1'b0;
        if (temp_s9_reg < TEMP_LOW)
        begin
            temp_out_next = 15'(TEMP_LOW);
            oor_next      = 1'b1;
        end
        else if (temp_s9_reg > TEMP_HIGH)
        begin
            temp_out_next = 15'(TEMP_HIGH);
            oor_next      = 1'b1;
        end
        else
        begin
            temp_out_next = temp_s9_reg[14:0];
        end
        if (press_wide < 29'sd0)
        begin
            press_out_next = 17'd0;
            oor_next       = 1'b1;
        end
        else if (press_wide > PRESS_HIGH)
        begin
            press_out_next = PRESS_HIGH[16:0];
            oor_next       = 1'b1;
        end
        else
        begin
            press_out_next = press_wide[16:0];
        end
    end

    // valid bits through the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            v_reg   <= {v_reg[5:1], start && !busy};
            v9_reg  <= mul_valid;
            v10_reg <= v9_reg;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        d1_s1_reg     <= pressure_raw;
        dt_s1_reg     <= dt_next;

        d1_s2_reg     <= d1_s1_reg;
        prod_t_reg    <= prod_t_next;
        off_dt_reg    <= off_dt_next;
        sens_dt_reg   <= sens_dt_next;
        dt_sq_reg     <= dt_sq_next[47:0];

        d1_s3_reg     <= d1_s2_reg;
        delta_s3_reg  <= delta_next;
        temp_s3_reg   <= temp_next;
        off_s3_reg    <= off_next;
        sens_s3_reg   <= sens_next;
        t2_s3_reg     <= dt_sq_reg[47:31];
        cold_s3_reg   <= cold_next;
        frigid_s3_reg <= frigid_next;

        d1_s4_reg     <= d1_s3_reg;
        temp_s4_reg   <= temp_s3_reg;
        off_s4_reg    <= off_s3_reg;
        sens_s4_reg   <= sens_s3_reg;
        t2_s4_reg     <= t2_s3_reg;
        cold_s4_reg   <= cold_s3_reg;
        frigid_s4_reg <= frigid_s3_reg;
        a_reg         <= a_sq[34:0];
        b_reg         <= b_sq[35:0];

        d1_s5_reg     <= d1_s4_reg;
        temp_s5_reg   <= temp_s4_reg;
        off_s5_reg    <= off_s4_reg;
        sens_s5_reg   <= sens_s4_reg;
        t2_s5_reg     <= t2_s4_reg;
        cold_s5_reg   <= cold_s4_reg;
        off2_reg      <= off2_next;
        sens2_reg     <= sens2_next;

        d1_s6_reg     <= d1_s5_reg;
        temp_s6_reg   <= temp_c;
        off_s6_reg    <= off_c;
        sens_s6_reg   <= sens_c;

        temp_s7_reg   <= temp_s6_reg;
        off_s7_reg    <= off_s6_reg;
        temp_s8_reg   <= temp_s7_reg;
        off_s8_reg    <= off_s7_reg;

        temp_s9_reg   <= temp_s8_reg;
        x_reg         <= x_next;

        temp_out_reg  <= temp_out_next;
        press_out_reg <= press_out_next;
        oor_reg       <= oor_next;
    end

    // D1 * SENS over two stages
    bptc_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[6]),
        .d1        (d1_s6_reg),
        .sens      (sens_s6_reg),
        .out_valid (mul_valid),
        .prod      (prod)
    );

    assign done              = v10_reg;
    assign temperature_centi = temp_out_reg;
    assign pressure_pa       = press_out_reg;
    assign out_of_range      = oor_reg;

endmodule

`default_nettype wire

>>> sv/bptc_mul.sv
`default_nettype none

module bptc_mul (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic [bptc_pkg::RAW_W-1:0]           d1,
    input  wire logic signed [bptc_pkg::SENS_W-1:0]   sens,
    output logic                                      out_valid,
    output logic signed [bptc_pkg::PROD_W-1:0]        prod
);
    import bptc_pkg::*;

    // sens split into an unsigned low half and a signed high half
    localparam int LO_W = 20;
    localparam int HI_W = SENS_W - LO_W;
    localparam int PP_W = RAW_W + LO_W;

    logic                   va_reg;
    logic                   vb_reg;
    logic [PP_W-1:0]        p_lo_reg;
    logic [PP_W-1:0]        p_lo_next;
    logic signed [PP_W-1:0] p_hi_reg;
    logic signed [PP_W-1:0] p_hi_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;

    always_comb
    begin
        p_lo_next = d1 * sens[LO_W-1:0];
        p_hi_next = $signed({1'b0, d1}) * $signed(sens[SENS_W-1:LO_W]);
        prod_next = ({{(PROD_W-PP_W){p_hi_reg[PP_W-1]}}, p_hi_reg} << LO_W)
                  + {{(PROD_W-PP_W){1'b0}}, p_lo_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_lo_reg <= p_lo_next;
        p_hi_reg <= p_hi_next;
        prod_reg <= prod_next;
    end

    assign out_valid = vb_reg;
    assign prod      = $signed(prod_reg);

endmodule

`default_nettype wire
